### rtl/kabf_pkg.sv
package kabf_pkg;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] measured_angle;
        logic signed [31:0] measured_rate;
        logic [31:0]        time_step;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] filtered_angle;
        logic signed [31:0] estimated_bias;
    } out_item_t;

    localparam int RegWidth = 25;
    localparam int IdxWidth = 2;

    localparam logic [IdxWidth-1:0] REG_Q_ANGLE = 2'd0;
    localparam logic [IdxWidth-1:0] REG_Q_BIAS  = 2'd1;
    localparam logic [IdxWidth-1:0] REG_R_MEAS  = 2'd2;

    localparam logic [RegWidth-1:0] Q_ANGLE_RESET = 25'd16777;
    localparam logic [RegWidth-1:0] Q_BIAS_RESET  = 25'd50332;
    localparam logic [RegWidth-1:0] R_MEAS_RESET  = 25'd503316;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_D,        // d = sat(rate - bias)
        OP_MUL_DDT,  // m = d*dt
        OP_ANG_P,    // angle = sat(angle + m)
        OP_MUL_T,    // t = p11*dt
        OP_BR,       // br = sat(t - p01 - p10 + qa)
        OP_MUL_BR,   // m = br*dt
        OP_P00,      // p00 = sat(p00 + m); p01 = sat(p01 - t)
        OP_P10,      // p10 = sat(p10 - t)
        OP_MUL_QB,   // m = qb*dt
        OP_P11,      // p11 = sat(p11 + m); s = p00 + r
        OP_DIV0,     // start k0 divide
        OP_DIV1,     // start k1 divide
        OP_Y,        // y = sat(meas - angle)
        OP_MUL_K0Y,
        OP_ANG_U,
        OP_MUL_K1Y,
        OP_BIAS_U,
        OP_MUL_K0P00,
        OP_MUL_K0P01,
        OP_MUL_K1P00,
        OP_MUL_K1P01,
        OP_COV_U
    } op_t;

    typedef struct packed {
        op_t  op;
        logic div_k1;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    // Scale a Q24 product by 2^-24 with half-up rounding and saturate.
    function automatic logic signed [31:0] scale_q24(input logic signed [65:0] p);
        logic signed [65:0] r;
        logic signed [41:0] q;
        begin
            r = p + 66'sd8388608;
            q = r[65:24];
            if (q > 42'sd2147483647) begin
                return 32'sh7FFFFFFF;
            end else if (q < -42'sd2147483648) begin
                return 32'sh80000000;
            end else begin
                return q[31:0];
            end
        end
    endfunction

endpackage

### rtl/kabf_divider.sv
// Restoring divider: quotient = (num * 2^24) / den, truncated toward zero,
// saturated to 32 bits. One quotient bit per cycle.
module kabf_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [33:0] den,
    output logic               busy,
    output logic signed [31:0] quot
);
    import kabf_pkg::*;

    localparam int QW = 57;

    logic [QW-1:0]  dividend_reg, dividend_next;
    logic [33:0]    rem_reg, rem_next;
    logic [32:0]    den_reg, den_next;
    logic [QW-1:0]  q_reg, q_next;
    logic           neg_reg, neg_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [33:0]    trial;
    logic [QW:0]    sq;

    always_comb
    begin
        dividend_next = dividend_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        q_next = q_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = '0;
        if (start) begin
            neg_next = num[31];
            dividend_next = {25'd0, (num[31] ? 32'(-33'(num)) : 32'(num))} << 24;
            den_next = den[32:0];
            rem_next = '0;
            q_next = '0;
            cnt_next = 6'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {rem_reg[32:0], dividend_reg[QW-1]};
            dividend_next = dividend_reg << 1;
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                q_next = {q_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    // Signed, saturated quotient.
    always_comb
    begin
        sq = neg_reg ? (0 - {1'b0, q_reg}) : {1'b0, q_reg};
        if (!neg_reg && q_reg > 57'd2147483647) begin
            quot = 32'sh7FFFFFFF;
        end else if (neg_reg && q_reg > 57'd2147483648) begin
            quot = 32'sh80000000;
        end else begin
            quot = sq[31:0];
        end
    end

    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg <= q_next;
        neg_reg <= neg_next;
    end

endmodule

### rtl/kabf_datapath.sv
// Filter state, shared multiplier and divider, driven by controller ops.
module kabf_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  kabf_pkg::dp_cmd_t           cmd,
    input  kabf_pkg::in_item_t          item,
    input  logic [kabf_pkg::RegWidth-1:0] q_angle,
    input  logic [kabf_pkg::RegWidth-1:0] q_bias,
    input  logic [kabf_pkg::RegWidth-1:0] r_meas,
    output kabf_pkg::dp_stat_t          stat,
    output logic signed [31:0]          angle,
    output logic signed [31:0]          bias
);
    import kabf_pkg::*;

    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] meas_reg, rate_reg;
    logic [31:0]        dt_reg;
    logic signed [31:0] d_reg, t_reg, br_reg, y_reg, m_reg, k0_reg, k1_reg;
    logic signed [31:0] mk_reg [4];
    logic signed [33:0] s_reg;
    logic signed [32:0] ma, mb;
    logic signed [65:0] mprod;
    logic signed [31:0] prod;
    logic               do_mul;
    logic               div_start;
    logic signed [31:0] div_num, div_q;
    logic               s_pos;

    assign s_pos = (s_reg > 34'sd0);

    // Operand select for the shared multiplier.
    always_comb
    begin
        ma = '0;
        mb = '0;
        do_mul = 1'b1;
        case (cmd.op)
            OP_MUL_DDT:   begin ma = 33'(d_reg);  mb = $signed({1'b0, dt_reg}); end
            OP_MUL_T:     begin ma = 33'(p11_reg); mb = $signed({1'b0, dt_reg}); end
            OP_MUL_BR:    begin ma = 33'(br_reg); mb = $signed({1'b0, dt_reg}); end
            OP_MUL_QB:    begin ma = $signed({8'd0, q_bias}); mb = $signed({1'b0, dt_reg}); end
            OP_MUL_K0Y:   begin ma = 33'(k0_reg); mb = 33'(y_reg); end
            OP_MUL_K1Y:   begin ma = 33'(k1_reg); mb = 33'(y_reg); end
            OP_MUL_K0P00: begin ma = 33'(k0_reg); mb = 33'(p00_reg); end
            OP_MUL_K0P01: begin ma = 33'(k0_reg); mb = 33'(p01_reg); end
            OP_MUL_K1P00: begin ma = 33'(k1_reg); mb = 33'(p00_reg); end
            OP_MUL_K1P01: begin ma = 33'(k1_reg); mb = 33'(p01_reg); end
            default:      do_mul = 1'b0;
        endcase
        mprod = ma * mb;
        prod = scale_q24(mprod);
    end

    assign div_start = (cmd.op == OP_DIV0) || (cmd.op == OP_DIV1);
    assign div_num = cmd.div_k1 ? p10_reg : p00_reg;

    kabf_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_reg),
        .busy  (stat.div_busy),
        .quot  (div_q)
    );

    // State updates per operation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ang_reg <= '0;
            bias_reg <= '0;
            p00_reg <= '0;
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= '0;
        end else begin
            case (cmd.op)
                OP_CLEAR:
                begin
                    ang_reg <= '0;
                    bias_reg <= '0;
                    p00_reg <= '0;
                    p01_reg <= '0;
                    p10_reg <= '0;
                    p11_reg <= '0;
                end
                OP_ANG_P: ang_reg <= sat32(35'(ang_reg) + 35'(m_reg));
                OP_P00:
                begin
                    p00_reg <= sat32(35'(p00_reg) + 35'(m_reg));
                    p01_reg <= sat32(35'(p01_reg) - 35'(t_reg));
                end
                OP_P10: p10_reg <= sat32(35'(p10_reg) - 35'(t_reg));
                OP_P11: p11_reg <= sat32(35'(p11_reg) + 35'(m_reg));
                OP_ANG_U: ang_reg <= sat32(35'(ang_reg) + 35'(m_reg));
                OP_BIAS_U: bias_reg <= sat32(35'(bias_reg) + 35'(m_reg));
                OP_COV_U:
                begin
                    p00_reg <= sat32(35'(p00_reg) - 35'(mk_reg[0]));
                    p01_reg <= sat32(35'(p01_reg) - 35'(mk_reg[1]));
                    p10_reg <= sat32(35'(p10_reg) - 35'(mk_reg[2]));
                    p11_reg <= sat32(35'(p11_reg) - 35'(mk_reg[3]));
                end
                default: ;
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (do_mul) begin
            m_reg <= prod;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                meas_reg <= item.measured_angle;
                rate_reg <= item.measured_rate;
                dt_reg <= item.time_step;
            end
            OP_D: d_reg <= sat32(35'(rate_reg) - 35'(bias_reg));
            OP_MUL_T: t_reg <= prod;
            // The whole bracket is summed exactly and saturated once.
            OP_BR: br_reg <= sat32(35'(t_reg) - 35'(p01_reg) - 35'(p10_reg)
                                   + 35'($signed({1'b0, q_angle})));
            OP_P11: s_reg <= 34'(p00_reg) + $signed({9'd0, r_meas});
            OP_DIV1: k0_reg <= s_pos ? div_q : 32'sd0;
            OP_Y:
            begin
                k1_reg <= s_pos ? div_q : 32'sd0;
                y_reg <= sat32(35'(meas_reg) - 35'(ang_reg));
            end
            OP_MUL_K0P00: mk_reg[0] <= prod;
            OP_MUL_K0P01: mk_reg[1] <= prod;
            OP_MUL_K1P00: mk_reg[2] <= prod;
            OP_MUL_K1P01: mk_reg[3] <= prod;
            default: ;
        endcase
    end

    assign angle = ang_reg;
    assign bias = bias_reg;

endmodule

### rtl/kabf_ctrl.sv
// Sequencer: clears the filter state or steps the datapath through one update, waiting on the divider.
module kabf_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_kind,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  kabf_pkg::dp_stat_t stat,
    output kabf_pkg::dp_cmd_t  cmd
);
    import kabf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign accept = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        cmd.op = OP_NONE;
        cmd.div_k1 = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    cmd.op = in_kind ? OP_CLEAR : OP_LOAD;
                    state_next = in_kind ? S_OUT : S_RUN;
                    op_next = OP_D;
                end
            end
            S_RUN:
            begin
                cmd.op = op_reg;
                op_next = op_t'(op_reg + 5'd1);
                if (op_reg == OP_DIV0 || op_reg == OP_DIV1) begin
                    state_next = S_WAIT;
                    cmd.div_k1 = (op_reg == OP_DIV1);
                end
                if (op_reg == OP_COV_U) begin
                    state_next = S_OUT;
                    op_next = OP_NONE;
                end
            end
            S_WAIT:
            begin
                if (!stat.div_busy) begin
                    state_next = S_RUN;
                end
            end
            S_OUT:
            begin
                if (!out_stall) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            op_reg <= OP_NONE;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end

endmodule

### rtl/kalman_angle_bias_filter.sv
// Two-state (angle, gyro bias) Kalman filter in fixed point. One item is
// taken at a time; an update item runs the two serial divisions for the
// gains and a sequence of steps on one shared multiplier. A clear item
// skips all of these. The result beat is held until taken, and the next
// item is accepted after that.
module kalman_angle_bias_filter
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  kabf_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output kabf_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic [kabf_pkg::IdxWidth-1:0] cfg_index,
    input  logic [kabf_pkg::RegWidth-1:0] cfg_data
);
    import kabf_pkg::*;

    logic [RegWidth-1:0] q_angle_reg, q_bias_reg, r_meas_reg;
    dp_cmd_t             cmd;
    dp_stat_t            stat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            q_angle_reg <= Q_ANGLE_RESET;
            q_bias_reg <= Q_BIAS_RESET;
            r_meas_reg <= R_MEAS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_Q_ANGLE: q_angle_reg <= cfg_data;
                REG_Q_BIAS:  q_bias_reg <= cfg_data;
                REG_R_MEAS:  r_meas_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    kabf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_kind   (in_data.kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    kabf_datapath u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .item    (in_data),
        .q_angle (q_angle_reg),
        .q_bias  (q_bias_reg),
        .r_meas  (r_meas_reg),
        .stat    (stat),
        .angle   (out_data.filtered_angle),
        .bias    (out_data.estimated_bias)
    );

endmodule
